// ===== rtl/ring_message_queue_with_jam_assert.svh =====
// Assertion shorthands for the message queue checker.
// Each one expands to a labeled concurrent assertion sampled on the rising clock edge,
// switched off while reset is high, and reporting through $error.
`ifndef RING_MESSAGE_QUEUE_WITH_JAM_ASSERT_SVH
`define RING_MESSAGE_QUEUE_WITH_JAM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RMQJ_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("message queue check failed");

// The consequent must hold in the cycle after the antecedent.
`define RMQJ_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("message queue check failed");

`endif

// ===== rtl/rmqj_pkg.sv =====
`default_nettype none

package rmqj_pkg;

  localparam int DEFAULT_MAX_SLOTS = 16;
  localparam int MSG_W = 32;
  localparam int CNT_W = 5;
  localparam int CAP_RESET = 16;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Register indexes (byte address divided by four).
  localparam logic [ADDR_W-3:0] REG_CAPACITY = '0;

  // Request kinds.
  localparam logic [1:0] REQ_SEND    = 2'd0;
  localparam logic [1:0] REQ_JAM     = 2'd1;
  localparam logic [1:0] REQ_RECEIVE = 2'd2;
  localparam logic [1:0] REQ_PEEK    = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_WAIT    = 2'd2;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [MSG_W-1:0] message;
    logic             wait_if_unavailable;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [MSG_W-1:0] message_out;
    logic [CNT_W-1:0] used_count;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic finish;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/rmqj_ram.sv =====
`default_nettype none

module rmqj_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire logic [WIDTH-1:0]     wr_data,
  input  wire logic                 rd_en,
  input  wire logic [AW-1:0]        rd_addr,
  output      logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rmqj_ctrl.sv =====
`default_nettype none

module rmqj_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output      logic           req_stall,
  input  wire rmqj_pkg::stat_t stat,
  output      rmqj_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    IDLE,
    EXEC,
    FIN
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      req_stall <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (req_valid) begin
            state     <= EXEC;
            req_stall <= 1'b1;
          end
        end
        EXEC: begin
          state <= FIN;
        end
        FIN: begin
          if (stat.out_free) begin
            state     <= IDLE;
            req_stall <= 1'b0;
          end
        end
        default: begin
          state     <= IDLE;
          req_stall <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd.load   = (state == IDLE) && req_valid;
    cmd.exec   = (state == EXEC);
    cmd.finish = (state == FIN) && stat.out_free;
  end

endmodule

`default_nettype wire

// ===== rtl/rmqj_datapath.sv =====
`default_nettype none

module rmqj_datapath #(
  parameter int MAX_SLOTS = rmqj_pkg::DEFAULT_MAX_SLOTS,
  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire rmqj_pkg::cmd_t                cmd,
  output      rmqj_pkg::stat_t               stat,
  input  wire rmqj_pkg::req_t                req,
  output      logic                          rsp_valid,
  input  wire logic                          rsp_stall,
  output      rmqj_pkg::rsp_t                rsp,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rmqj_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [rmqj_pkg::DATA_W-1:0]   pwdata,
  output      logic [rmqj_pkg::DATA_W-1:0]   prdata,
  output      logic                          ram_wr_en,
  output      logic [IDX_W-1:0]              ram_wr_addr,
  output      logic [rmqj_pkg::MSG_W-1:0]    ram_wr_data,
  output      logic                          ram_rd_en,
  output      logic [IDX_W-1:0]              ram_rd_addr,
  input  wire logic [rmqj_pkg::MSG_W-1:0]    ram_rd_data
);

  localparam int CNT_W = rmqj_pkg::CNT_W;
  localparam int SUM_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
  localparam int CAP_MAX_I = (MAX_SLOTS > 31) ? 31 : MAX_SLOTS;
  localparam int CAP_RST_I = (CAP_MAX_I < rmqj_pkg::CAP_RESET) ? CAP_MAX_I
                                                               : rmqj_pkg::CAP_RESET;
  localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(CAP_MAX_I);
  localparam logic [CNT_W-1:0] CAP_RST = CNT_W'(CAP_RST_I);

  rmqj_pkg::req_t    req_reg;
  logic [IDX_W-1:0]  head;
  logic [IDX_W-1:0]  head_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  capacity;
  logic [1:0]        pend_status;
  logic              pend_read;
  logic [CNT_W-1:0]  pend_count;

  logic              cfg_wr;
  logic [CNT_W-1:0]  cap_raw;
  logic [CNT_W-1:0]  cap_clamped;

  logic              is_put;
  logic              is_jam;
  logic              ok;
  logic [1:0]        status_now;
  logic [SUM_W-1:0]  cap_ext;
  logic [SUM_W-1:0]  tail_sum;
  logic [SUM_W-1:0]  inc_sum;
  logic [SUM_W-1:0]  dec_sum;
  logic [IDX_W-1:0]  tail_idx;
  logic [IDX_W-1:0]  head_inc;
  logic [IDX_W-1:0]  head_dec;

  // Register port.
  assign cfg_wr  = psel && penable && pwrite && (paddr[rmqj_pkg::ADDR_W-1:2] ==
                                                 rmqj_pkg::REG_CAPACITY);
  assign cap_raw = pwdata[CNT_W-1:0];
  assign prdata  = {{(rmqj_pkg::DATA_W-CNT_W){1'b0}}, capacity};

  always_comb begin
    cap_clamped = cap_raw;
    if (cap_raw == '0) begin
      cap_clamped = CNT_W'(1);
    end else if (cap_raw > CAP_MAX) begin
      cap_clamped = CAP_MAX;
    end
  end

  // Index arithmetic; every sum stays below twice the capacity, so one
  // compare and subtract wraps it.
  always_comb begin
    cap_ext  = SUM_W'(capacity);
    tail_sum = SUM_W'(head) + SUM_W'(count);
    if (tail_sum >= cap_ext) begin
      tail_sum = tail_sum - cap_ext;
    end
    inc_sum = SUM_W'(head) + SUM_W'(1);
    if (inc_sum >= cap_ext) begin
      inc_sum = inc_sum - cap_ext;
    end
    if (head == '0) begin
      dec_sum = cap_ext - SUM_W'(1);
    end else begin
      dec_sum = SUM_W'(head) - SUM_W'(1);
    end
    tail_idx = tail_sum[IDX_W-1:0];
    head_inc = inc_sum[IDX_W-1:0];
    head_dec = dec_sum[IDX_W-1:0];
  end

  always_comb begin
    is_jam = (req_reg.req_type == rmqj_pkg::REQ_JAM);
    is_put = (req_reg.req_type == rmqj_pkg::REQ_SEND) || is_jam;
    ok     = is_put ? (count < capacity) : (count != '0);
    if (ok) begin
      status_now = rmqj_pkg::ST_DONE;
    end else if (req_reg.wait_if_unavailable) begin
      status_now = rmqj_pkg::ST_WAIT;
    end else begin
      status_now = rmqj_pkg::ST_REFUSED;
    end

    head_next  = head;
    count_next = count;
    if (ok) begin
      if (is_put) begin
        count_next = count + CNT_W'(1);
        if (is_jam) begin
          head_next = head_dec;
        end
      end else if (req_reg.req_type == rmqj_pkg::REQ_RECEIVE) begin
        count_next = count - CNT_W'(1);
        head_next  = head_inc;
      end
    end
  end

  assign ram_wr_en   = cmd.exec && ok && is_put;
  assign ram_wr_addr = is_jam ? head_dec : tail_idx;
  assign ram_wr_data = req_reg.message;
  assign ram_rd_en   = cmd.exec && ok && !is_put;
  assign ram_rd_addr = head;

  assign stat.out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_reg <= req;
    end
    if (cmd.exec) begin
      pend_status <= status_now;
      pend_read   <= ok && !is_put;
      pend_count  <= count_next;
    end
    if (cmd.finish) begin
      rsp.status      <= pend_status;
      rsp.message_out <= pend_read ? ram_rd_data : '0;
      rsp.used_count  <= pend_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      capacity  <= CAP_RST;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        capacity <= cap_clamped;
        head     <= '0;
        count    <= '0;
      end else if (cmd.exec) begin
        head  <= head_next;
        count <= count_next;
      end
      if (cmd.finish) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ring_message_queue_with_jam.sv =====
// Ring message queue with head insertion. Each request transaction carries
// one of four kinds: send appends its message at the tail, jam inserts it in
// front of the head, receive removes and returns the head message, and peek
// returns the head message without removing it. Every request produces
// exactly one response transaction with a status (done, refused, or must
// wait and retry), the head message for a completed receive or peek (zero
// otherwise), and the number of messages held afterwards. A send or jam on a
// full queue, or a receive or peek on an empty one, leaves the queue as it
// was and reports refused, or must-wait when the request's wait flag is set.
// The capacity register (address 0, bits 4:0) selects how many of the
// MAX_SLOTS slots are in use; zero is taken as one and values above the
// slot count are clamped. Writing it empties the queue, and it should only
// be written while no transaction is in flight. A request passes through
// capture, execute and finish: capture registers it, execute updates the
// indices and accesses the message store, and finish loads the response
// register with the store's registered read data. A new request is accepted
// only once the previous one has finished; a waiting response holds the
// next request in its final step until the response register frees up.
// There is no clearing pass after reset.

`default_nettype none

module ring_message_queue_with_jam #(
  parameter int MAX_SLOTS = rmqj_pkg::DEFAULT_MAX_SLOTS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  output      logic                        req_stall,
  input  wire rmqj_pkg::req_t              req,
  output      logic                        rsp_valid,
  input  wire logic                        rsp_stall,
  output      rmqj_pkg::rsp_t              rsp,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rmqj_pkg::ADDR_W-1:0] paddr,
  input  wire logic [rmqj_pkg::DATA_W-1:0] pwdata,
  output      logic [rmqj_pkg::DATA_W-1:0] prdata,
  output      logic                        pready
);

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  rmqj_pkg::cmd_t             cmd;
  rmqj_pkg::stat_t            stat;
  logic                       ram_wr_en;
  logic [IDX_W-1:0]           ram_wr_addr;
  logic [rmqj_pkg::MSG_W-1:0] ram_wr_data;
  logic                       ram_rd_en;
  logic [IDX_W-1:0]           ram_rd_addr;
  logic [rmqj_pkg::MSG_W-1:0] ram_rd_data;

  // The register port never inserts wait states.
  assign pready = 1'b1;

  // The controller sequences each transaction through capture, execute and
  // finish; it only advances out of finish when the response register is
  // free or is being emptied in the same cycle.
  rmqj_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the head index, the fill count, the capacity
  // register and the response register.
  rmqj_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  // Message store: one write port for send and jam, one registered read
  // port for the head message. Its contents are not reset; only slots that
  // have been written are ever read back.
  rmqj_ram #(
    .WIDTH (rmqj_pkg::MSG_W),
    .DEPTH (MAX_SLOTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule

`default_nettype wire

// ===== rtl/rmqj_checker.sv =====
`default_nettype none

`include "ring_message_queue_with_jam_assert.svh"

module rmqj_checker #(
  parameter int MAX_SLOTS = rmqj_pkg::DEFAULT_MAX_SLOTS
) (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        rsp_valid,
  input wire logic                        rsp_stall,
  input wire rmqj_pkg::rsp_t              rsp,
  input wire logic [rmqj_pkg::DATA_W-1:0] prdata
);

  localparam int CNT_W = rmqj_pkg::CNT_W;
  localparam int CAP_MAX_I = (MAX_SLOTS > 31) ? 31 : MAX_SLOTS;
  localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(CAP_MAX_I);

  logic [CNT_W-1:0] cap_rd;
  logic             not_done;

  assign cap_rd   = prdata[CNT_W-1:0];
  assign not_done = (rsp.status != rmqj_pkg::ST_DONE);

  // A stalled response holds.
  `RMQJ_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

  // Only a completed transaction carries a message word.
  `RMQJ_ASSERT_IMP(a_msg_zero, clk, rst, rsp_valid && not_done, rsp.message_out == '0)

  // The fill count never exceeds the largest capacity.
  `RMQJ_ASSERT_IMP(a_count_max, clk, rst, rsp_valid, rsp.used_count <= CAP_MAX)

  // The capacity read back is always within its clamped range.
  `RMQJ_ASSERT_IMP(a_cap_range, clk, rst, 1'b1, (cap_rd != '0) && (cap_rd <= CAP_MAX))

endmodule

bind ring_message_queue_with_jam rmqj_checker #(
  .MAX_SLOTS (MAX_SLOTS)
) u_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp),
  .prdata    (prdata)
);

`default_nettype wire
